@@ rtl/core/dpc_pkg.sv @@
`default_nettype none
package dpc_pkg;

  // Defaults for the top-level parameters
  localparam int NODE_COUNT_DEF = 1024;
  localparam int EDGE_COUNT_DEF = 4096;
  localparam int COUNT_BITS_DEF = 64;

  // Field widths fixed by the interface
  localparam int NODE_FIELD_W = 10;
  localparam int FIELD_W      = 64;
  localparam int IN_DATA_W    = 24;
  localparam int OUT_DATA_W   = 128;
  localparam int OUT_USER_W   = 2;
  localparam int CFG_DATA_W   = 32;
  localparam int CFG_ADDR_W   = 4;

  // Multiplier datapath: one half-width multiply per cycle
  localparam int MUL_W  = 64;
  localparam int HALF_W = MUL_W / 2;

  // Request kinds carried on in_tuser
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_RUN  = 1'b1;

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_SOURCE = 2'd0;
  localparam logic [1:0] REG_WAY_A  = 2'd1;
  localparam logic [1:0] REG_WAY_B  = 2'd2;
  localparam logic [1:0] REG_TARGET = 2'd3;

endpackage
`default_nettype wire

@@ rtl/core/dpc_ram.sv @@
`default_nettype none
module dpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/core/dpc_mul.sv @@
`default_nettype none
module dpc_mul (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic [dpc_pkg::MUL_W-1:0] a,
  input  wire logic [dpc_pkg::MUL_W-1:0] b,
  output      logic                    done,
  output      logic [dpc_pkg::MUL_W-1:0] prod
);
  import dpc_pkg::*;

  // Wrapped product in three steps: lo*lo, then both cross terms shifted up.
  logic [MUL_W-1:0]  a_r, b_r, acc_r, acc_nxt;
  logic [1:0]        phase_r;
  logic              busy_r, done_r;
  logic [HALF_W-1:0] op_a, op_b;
  logic [MUL_W-1:0]  pp;

  always_comb begin
    op_a = a_r[HALF_W-1:0];
    op_b = b_r[HALF_W-1:0];
    unique case (phase_r)
      2'd1:    op_b = b_r[MUL_W-1:HALF_W];
      2'd2:    op_a = a_r[MUL_W-1:HALF_W];
      default: ;
    endcase
    pp = MUL_W'(op_a) * MUL_W'(op_b);
    if (phase_r == 2'd0) begin
      acc_nxt = pp;
    end else begin
      acc_nxt = acc_r + {pp[HALF_W-1:0], {HALF_W{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      phase_r <= 2'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        phase_r <= 2'd0;
      end else if (busy_r) begin
        phase_r <= phase_r + 2'd1;
        if (phase_r == 2'd2) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule
`default_nettype wire

@@ rtl/core/dag_path_counter.sv @@
`default_nettype none
// Path counter over a directed graph loaded one edge at a time. A load transfer
// (in_tuser = 0) stores edge src -> dst: the idle state reads the origin's
// chain head and the destination's in-degree, ST_LOAD_WR writes both back plus
// the edge entry. Edges past EDGE_COUNT are dropped and flagged. A run transfer
// (in_tuser = 1) seeds X/Y/Z at the source and the two waypoints, scans all
// nodes for in-degree zero (ST_SCAN_RD, ST_SCAN_CHK), then walks in Kahn order
// (ST_POP_RD, ST_POP_NODE, ST_POP_GOT per node; ST_EDGE_RD, ST_EDGE_GOT and
// ST_EDGE_WR per edge). The via-both sum then takes 4 products on one 32x32
// multiplier. One result transfer comes out per run; loads give none. Counts
// wrap at 2^COUNT_BITS. After reset and after each run a clearing pass over all
// NODE_COUNT nodes resets the node memories; no item is taken then, nor while
// a result waits. Registers are to be written over the APB port only while the
// block is idle, which the block does not enforce. NODE_COUNT must be a power
// of two; node indices and registers are taken modulo NODE_COUNT.
module dag_path_counter #(
  parameter int NODE_COUNT = dpc_pkg::NODE_COUNT_DEF,
  parameter int EDGE_COUNT = dpc_pkg::EDGE_COUNT_DEF,
  parameter int COUNT_BITS = dpc_pkg::COUNT_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // in_tdata: src_node[9:0], dst_node[19:10], zero pad to 24
  input  wire logic                             in_tvalid,
  output      logic                             in_tready,
  input  wire logic [dpc_pkg::IN_DATA_W-1:0]    in_tdata,
  // in_tuser: req_type
  input  wire logic                             in_tuser,
  // out_tdata: paths_direct[63:0], paths_via_both[127:64]
  output      logic                             out_tvalid,
  input  wire logic                             out_tready,
  output      logic [dpc_pkg::OUT_DATA_W-1:0]   out_tdata,
  // out_tuser: edges_dropped[0], cycle_left[1]
  output      logic [dpc_pkg::OUT_USER_W-1:0]   out_tuser,
  input  wire logic                             cfg_psel,
  input  wire logic                             cfg_penable,
  input  wire logic                             cfg_pwrite,
  input  wire logic [dpc_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  wire logic [dpc_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output      logic [dpc_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output      logic                             cfg_pready
);
  import dpc_pkg::*;

  localparam int NW = $clog2(NODE_COUNT);
  localparam int EW = $clog2(EDGE_COUNT);
  localparam int PW = EW + 1;           // edge pointer, EDGE_COUNT = empty chain
  localparam int QW = NW + 1;
  localparam int CB = COUNT_BITS;
  localparam int CW = 3 * CB;           // {z, y, x}
  localparam int XW = NW + PW;          // edge entry {link, target}

  localparam logic [PW-1:0] NO_EDGE   = PW'(EDGE_COUNT);
  localparam logic [NW-1:0] LAST_NODE = NW'(NODE_COUNT - 1);
  localparam logic [QW-1:0] Q_LIMIT   = QW'(NODE_COUNT);
  localparam logic [CB-1:0] ONE       = CB'(1);

  localparam logic [4:0] ST_CLEAR    = 5'd0;
  localparam logic [4:0] ST_IDLE     = 5'd1;
  localparam logic [4:0] ST_LOAD_WR  = 5'd2;
  localparam logic [4:0] ST_SEED_RD  = 5'd3;
  localparam logic [4:0] ST_SEED_WR  = 5'd4;
  localparam logic [4:0] ST_SCAN_RD  = 5'd5;
  localparam logic [4:0] ST_SCAN_CHK = 5'd6;
  localparam logic [4:0] ST_POP_RD   = 5'd7;
  localparam logic [4:0] ST_POP_NODE = 5'd8;
  localparam logic [4:0] ST_POP_GOT  = 5'd9;
  localparam logic [4:0] ST_EDGE_RD  = 5'd10;
  localparam logic [4:0] ST_EDGE_GOT = 5'd11;
  localparam logic [4:0] ST_EDGE_WR  = 5'd12;
  localparam logic [4:0] ST_RES_RD   = 5'd13;
  localparam logic [4:0] ST_RES_GOT  = 5'd14;
  localparam logic [4:0] ST_MUL_GO   = 5'd15;
  localparam logic [4:0] ST_MUL_WAIT = 5'd16;

  function automatic logic [NW-1:0] node_of(input logic [NODE_FIELD_W-1:0] v);
    logic [NW+NODE_FIELD_W-1:0] ext;
    ext = {{NW{1'b0}}, v};
    return ext[NW-1:0];
  endfunction

  // ---------------- configuration registers ----------------
  logic [NODE_FIELD_W-1:0] src_cfg_r, way_a_cfg_r, way_b_cfg_r, tgt_cfg_r;
  logic                    cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_cfg_r   <= NODE_FIELD_W'(0);
      way_a_cfg_r <= NODE_FIELD_W'(1);
      way_b_cfg_r <= NODE_FIELD_W'(2);
      tgt_cfg_r   <= NODE_FIELD_W'(3);
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_SOURCE: src_cfg_r   <= cfg_pwdata[NODE_FIELD_W-1:0];
        REG_WAY_A:  way_a_cfg_r <= cfg_pwdata[NODE_FIELD_W-1:0];
        REG_WAY_B:  way_b_cfg_r <= cfg_pwdata[NODE_FIELD_W-1:0];
        REG_TARGET: tgt_cfg_r   <= cfg_pwdata[NODE_FIELD_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_SOURCE: cfg_prdata = CFG_DATA_W'(src_cfg_r);
      REG_WAY_A:  cfg_prdata = CFG_DATA_W'(way_a_cfg_r);
      REG_WAY_B:  cfg_prdata = CFG_DATA_W'(way_b_cfg_r);
      REG_TARGET: cfg_prdata = CFG_DATA_W'(tgt_cfg_r);
    endcase
  end

  logic [NW-1:0] s_node, a_node, b_node, t_node;
  assign s_node = node_of(src_cfg_r);
  assign a_node = node_of(way_a_cfg_r);
  assign b_node = node_of(way_b_cfg_r);
  assign t_node = node_of(tgt_cfg_r);

  // ---------------- memories ----------------
  logic          deg_we, head_we, cnt_we, edge_we, q_we;
  logic [NW-1:0] deg_waddr, deg_raddr, head_waddr, head_raddr;
  logic [NW-1:0] cnt_waddr, cnt_raddr, q_waddr, q_raddr;
  logic [EW-1:0] edge_waddr, edge_raddr;
  logic [PW-1:0] deg_wdata, deg_rdata, head_wdata, head_rdata;
  logic [CW-1:0] cnt_wdata, cnt_rdata;
  logic [XW-1:0] edge_wdata, edge_rdata;
  logic [NW-1:0] q_wdata, q_rdata;

  dpc_ram #(.WIDTH(PW), .DEPTH(NODE_COUNT)) u_deg (
    .clk, .we(deg_we), .waddr(deg_waddr), .wdata(deg_wdata),
    .raddr(deg_raddr), .rdata(deg_rdata));
  dpc_ram #(.WIDTH(PW), .DEPTH(NODE_COUNT)) u_head (
    .clk, .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
    .raddr(head_raddr), .rdata(head_rdata));
  dpc_ram #(.WIDTH(CW), .DEPTH(NODE_COUNT)) u_cnt (
    .clk, .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(cnt_raddr), .rdata(cnt_rdata));
  dpc_ram #(.WIDTH(XW), .DEPTH(EDGE_COUNT)) u_edge (
    .clk, .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
    .raddr(edge_raddr), .rdata(edge_rdata));
  dpc_ram #(.WIDTH(NW), .DEPTH(NODE_COUNT)) u_queue (
    .clk, .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(q_rdata));

  // ---------------- multiplier ----------------
  logic             mul_start, mul_done;
  logic [MUL_W-1:0] mul_a, mul_b, mul_prod;

  dpc_mul u_mul (
    .clk, .rst_n, .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .prod(mul_prod));

  // ---------------- control ----------------
  logic [4:0]      state_r, state_nxt;
  logic [NW-1:0]   idx_r, idx_nxt;
  logic [1:0]      step_r, step_nxt;         // seed, result read or product index
  logic [QW-1:0]   qhead_r, qhead_nxt, qtail_r, qtail_nxt;
  logic [PW-1:0]   e_r, e_nxt;
  logic [NW-1:0]   d_r, d_nxt, from_r, from_nxt, to_r, to_nxt;
  logic [PW-1:0]   edges_r, edges_nxt, used_r, used_nxt;
  logic            ovf_r, ovf_nxt;
  logic [CW-1:0]   cn_r, cn_nxt, ca_r, ca_nxt, cbv_r, cbv_nxt, ct_r, ct_nxt;
  logic [MUL_W-1:0] p_r, p_nxt, v1_r, v1_nxt, via_sum;
  logic            out_valid_r, out_valid_nxt;
  logic [FIELD_W-1:0] out_direct_r, out_direct_nxt, out_via_r, out_via_nxt;
  logic [OUT_USER_W-1:0] out_flags_r, out_flags_nxt;
  logic            in_xfer;
  logic [NW-1:0]   in_from, in_to, seed_node, res_node;

  assign in_tready = (state_r == ST_IDLE) && !out_valid_r;
  assign in_xfer   = in_tvalid && in_tready;
  assign in_from   = node_of(in_tdata[NODE_FIELD_W-1:0]);
  assign in_to     = node_of(in_tdata[2*NODE_FIELD_W-1:NODE_FIELD_W]);
  assign via_sum   = v1_r + mul_prod;

  always_comb begin
    unique case (step_r)
      2'd0:    seed_node = s_node;
      2'd1:    seed_node = a_node;
      default: seed_node = b_node;
    endcase
    unique case (step_r)
      2'd0:    res_node = a_node;
      2'd1:    res_node = b_node;
      default: res_node = t_node;
    endcase
    // X[a]*Y[b]*Z[t] + X[b]*Z[a]*Y[t]
    unique case (step_r)
      2'd0: begin
        mul_a = MUL_W'(ca_r[CB-1:0]);
        mul_b = MUL_W'(cbv_r[2*CB-1:CB]);
      end
      2'd1: begin
        mul_a = p_r;
        mul_b = MUL_W'(ct_r[3*CB-1:2*CB]);
      end
      2'd2: begin
        mul_a = MUL_W'(cbv_r[CB-1:0]);
        mul_b = MUL_W'(ca_r[3*CB-1:2*CB]);
      end
      default: begin
        mul_a = p_r;
        mul_b = MUL_W'(ct_r[2*CB-1:CB]);
      end
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    step_nxt       = step_r;
    qhead_nxt      = qhead_r;
    qtail_nxt      = qtail_r;
    e_nxt          = e_r;
    d_nxt          = d_r;
    from_nxt       = from_r;
    to_nxt         = to_r;
    edges_nxt      = edges_r;
    used_nxt       = used_r;
    ovf_nxt        = ovf_r;
    cn_nxt         = cn_r;
    ca_nxt         = ca_r;
    cbv_nxt        = cbv_r;
    ct_nxt         = ct_r;
    p_nxt          = p_r;
    v1_nxt         = v1_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_direct_nxt = out_direct_r;
    out_via_nxt    = out_via_r;
    out_flags_nxt  = out_flags_r;
    mul_start      = 1'b0;

    deg_we     = 1'b0;
    deg_waddr  = idx_r;
    deg_wdata  = '0;
    deg_raddr  = idx_r;
    head_we    = 1'b0;
    head_waddr = idx_r;
    head_wdata = NO_EDGE;
    head_raddr = idx_r;
    cnt_we     = 1'b0;
    cnt_waddr  = idx_r;
    cnt_wdata  = '0;
    cnt_raddr  = idx_r;
    edge_we    = 1'b0;
    edge_waddr = edges_r[EW-1:0];
    edge_wdata = {head_rdata, to_r};
    edge_raddr = e_r[EW-1:0];
    q_we       = 1'b0;
    q_waddr    = qtail_r[NW-1:0];
    q_wdata    = idx_r;
    q_raddr    = qhead_r[NW-1:0];

    unique case (state_r)
      ST_CLEAR: begin
        deg_we  = 1'b1;
        head_we = 1'b1;
        cnt_we  = 1'b1;
        idx_nxt = idx_r + NW'(1);
        if (idx_r == LAST_NODE) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        head_raddr = in_from;
        deg_raddr  = in_to;
        if (in_xfer) begin
          if (in_tuser == REQ_RUN) begin
            step_nxt  = 2'd0;
            idx_nxt   = '0;
            qhead_nxt = '0;
            qtail_nxt = '0;
            used_nxt  = '0;
            state_nxt = ST_SEED_RD;
          end else if (edges_r < NO_EDGE) begin
            from_nxt  = in_from;
            to_nxt    = in_to;
            state_nxt = ST_LOAD_WR;
          end else begin
            ovf_nxt = 1'b1;
          end
        end
      end
      ST_LOAD_WR: begin
        // new edge goes to the front of the origin's chain
        edge_we    = 1'b1;
        head_we    = 1'b1;
        head_waddr = from_r;
        head_wdata = edges_r;
        deg_we     = 1'b1;
        deg_waddr  = to_r;
        deg_wdata  = deg_rdata + PW'(1);
        edges_nxt  = edges_r + PW'(1);
        state_nxt  = ST_IDLE;
      end
      ST_SEED_RD: begin
        cnt_raddr = seed_node;
        state_nxt = ST_SEED_WR;
      end
      ST_SEED_WR: begin
        // read-modify-write so that coinciding seeds all land
        cnt_we    = 1'b1;
        cnt_waddr = seed_node;
        cnt_wdata = cnt_rdata;
        unique case (step_r)
          2'd0:    cnt_wdata[CB-1:0]      = ONE;
          2'd1:    cnt_wdata[2*CB-1:CB]   = ONE;
          default: cnt_wdata[3*CB-1:2*CB] = ONE;
        endcase
        if (step_r == 2'd2) begin
          state_nxt = ST_SCAN_RD;
        end else begin
          step_nxt  = step_r + 2'd1;
          state_nxt = ST_SEED_RD;
        end
      end
      ST_SCAN_RD: begin
        state_nxt = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        if (deg_rdata == '0) begin
          q_we      = 1'b1;
          qtail_nxt = qtail_r + QW'(1);
        end
        idx_nxt = idx_r + NW'(1);
        if (idx_r == LAST_NODE) begin
          state_nxt = ST_POP_RD;
        end else begin
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_POP_RD: begin
        if (qhead_r == qtail_r) begin
          step_nxt  = 2'd0;
          state_nxt = ST_RES_RD;
        end else begin
          qhead_nxt = qhead_r + QW'(1);
          state_nxt = ST_POP_NODE;
        end
      end
      ST_POP_NODE: begin
        head_raddr = q_rdata;
        cnt_raddr  = q_rdata;
        state_nxt  = ST_POP_GOT;
      end
      ST_POP_GOT: begin
        e_nxt     = head_rdata;
        cn_nxt    = cnt_rdata;
        state_nxt = ST_EDGE_RD;
      end
      ST_EDGE_RD: begin
        if (e_r >= NO_EDGE) begin
          state_nxt = ST_POP_RD;
        end else begin
          state_nxt = ST_EDGE_GOT;
        end
      end
      ST_EDGE_GOT: begin
        d_nxt     = edge_rdata[NW-1:0];
        e_nxt     = edge_rdata[XW-1:NW];
        deg_raddr = edge_rdata[NW-1:0];
        cnt_raddr = edge_rdata[NW-1:0];
        state_nxt = ST_EDGE_WR;
      end
      ST_EDGE_WR: begin
        cnt_we    = 1'b1;
        cnt_waddr = d_r;
        cnt_wdata = {cnt_rdata[3*CB-1:2*CB] + cn_r[3*CB-1:2*CB],
                     cnt_rdata[2*CB-1:CB]   + cn_r[2*CB-1:CB],
                     cnt_rdata[CB-1:0]      + cn_r[CB-1:0]};
        used_nxt  = used_r + PW'(1);
        if (deg_rdata != '0) begin
          deg_we    = 1'b1;
          deg_waddr = d_r;
          deg_wdata = deg_rdata - PW'(1);
          if (deg_rdata == PW'(1) && qtail_r < Q_LIMIT) begin
            q_we      = 1'b1;
            q_wdata   = d_r;
            qtail_nxt = qtail_r + QW'(1);
          end
        end
        state_nxt = ST_EDGE_RD;
      end
      ST_RES_RD: begin
        cnt_raddr = res_node;
        state_nxt = ST_RES_GOT;
      end
      ST_RES_GOT: begin
        unique case (step_r)
          2'd0:    ca_nxt  = cnt_rdata;
          2'd1:    cbv_nxt = cnt_rdata;
          default: ct_nxt  = cnt_rdata;
        endcase
        if (step_r == 2'd2) begin
          step_nxt  = 2'd0;
          state_nxt = ST_MUL_GO;
        end else begin
          step_nxt  = step_r + 2'd1;
          state_nxt = ST_RES_RD;
        end
      end
      ST_MUL_GO: begin
        mul_start = 1'b1;
        state_nxt = ST_MUL_WAIT;
      end
      ST_MUL_WAIT: begin
        if (mul_done) begin
          unique case (step_r)
            2'd0, 2'd2: p_nxt  = mul_prod;
            2'd1:       v1_nxt = mul_prod;
            default: begin
              out_valid_nxt  = 1'b1;
              out_direct_nxt = FIELD_W'(ct_r[CB-1:0]);
              out_via_nxt    = FIELD_W'(via_sum[CB-1:0]);
              out_flags_nxt  = {used_r < edges_r, ovf_r};
            end
          endcase
          if (step_r == 2'd3) begin
            idx_nxt   = '0;
            edges_nxt = '0;
            used_nxt  = '0;
            ovf_nxt   = 1'b0;
            state_nxt = ST_CLEAR;
          end else begin
            step_nxt  = step_r + 2'd1;
            state_nxt = ST_MUL_GO;
          end
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      idx_r       <= '0;
      step_r      <= 2'd0;
      qhead_r     <= '0;
      qtail_r     <= '0;
      edges_r     <= '0;
      used_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      step_r      <= step_nxt;
      qhead_r     <= qhead_nxt;
      qtail_r     <= qtail_nxt;
      edges_r     <= edges_nxt;
      used_r      <= used_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e_r          <= e_nxt;
    d_r          <= d_nxt;
    from_r       <= from_nxt;
    to_r         <= to_nxt;
    cn_r         <= cn_nxt;
    ca_r         <= ca_nxt;
    cbv_r        <= cbv_nxt;
    ct_r         <= ct_nxt;
    p_r          <= p_nxt;
    v1_r         <= v1_nxt;
    out_direct_r <= out_direct_nxt;
    out_via_r    <= out_via_nxt;
    out_flags_r  <= out_flags_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_via_r, out_direct_r};
  assign out_tuser  = out_flags_r;

`ifndef SYNTHESIS
  a_edges_bound: assert property (@(posedge clk) disable iff (!rst_n)
    edges_r <= NO_EDGE)
    else $error("edge count past capacity");
  a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
    qhead_r <= qtail_r && qtail_r <= Q_LIMIT)
    else $error("ready queue pointers out of order");
  a_consumed_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= edges_r)
    else $error("more edges consumed than stored");
  a_result_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL_WAIT && mul_done && step_r == 2'd3) |=>
      (state_r == ST_CLEAR && out_valid_r && edges_r == '0))
    else $error("result not followed by clearing pass");
`endif

endmodule
`default_nettype wire
